// ===== rtl/core/mwd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mwd_pkg
// shared constants, types and arithmetic helpers of the mwd pulse filter
// ---------------------------------------------------------------------------
package mwd_pkg;

    localparam int MAX_DIFF_LENGTH = 1024;
    localparam int MAX_AVG_LENGTH  = 256;
    localparam int SAMPLE_WIDTH    = 16;

    localparam logic [2:0] REG_DECAY_COEFF    = 3'd0;
    localparam logic [2:0] REG_DIFF_LENGTH    = 3'd1;
    localparam logic [2:0] REG_AVG_LENGTH     = 3'd2;
    localparam logic [2:0] REG_AVG_RECIP      = 3'd3;
    localparam logic [2:0] REG_GRAD_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_BASIS_SKIP     = 3'd5;
    localparam logic [2:0] REG_BASIS_COUNT    = 3'd6;
    localparam logic [2:0] REG_BASIS_RECIP    = 3'd7;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_ACCUM = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_sample;   // capture sample, start deconvolution product
        logic step_deconv;   // update accumulator, read delay lines
        logic step_diff;     // difference and average delay lines
        logic step_scale;    // running sum scaled
        logic step_trig;     // trigger and window logic, state update
        logic step_height;   // pulse-height products
        logic step_finish;   // result out
    } mwd_cmd_t;

    // saturate a signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mwd_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mwd_ctrl
// sequencer for one sample through the datapath, output handshake
// ---------------------------------------------------------------------------
module mwd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mwd_pkg::mwd_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECONV = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_TRIG   = 3'd4;
    localparam logic [2:0] S_HEIGHT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // a finished result may wait while the next sample is taken
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_sample = accept;
                if (accept) state_next = S_DECONV;
            end
            S_DECONV:
            begin
                cmd.step_deconv = 1'b1;
                state_next      = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.step_diff = 1'b1;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.step_scale = 1'b1;
                state_next     = S_TRIG;
            end
            S_TRIG:
            begin
                cmd.step_trig = 1'b1;
                state_next    = S_HEIGHT;
            end
            S_HEIGHT:
            begin
                cmd.step_height = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.step_finish = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cmd) <= 1) else $error("more than one datapath command");
    a_finish_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_finish |=> out_valid) else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.load_sample) else $error("accept while busy");

endmodule
`default_nettype wire

// ===== rtl/core/mwd_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mwd_dp
// deconvolution, delay lines, averaging, trigger and pulse-height window
// ---------------------------------------------------------------------------
module mwd_dp #(
    parameter int MAX_DIFF_LENGTH = mwd_pkg::MAX_DIFF_LENGTH,
    parameter int MAX_AVG_LENGTH  = mwd_pkg::MAX_AVG_LENGTH,
    parameter int SAMPLE_WIDTH    = mwd_pkg::SAMPLE_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mwd_pkg::mwd_cmd_t           cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                        cfg_valid,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [31:0]                 cfg_data,
    output logic signed [31:0]               mwd_out,
    output logic                             trigger,
    output logic [31:0]                      trigger_time,
    output logic                             pulse_valid,
    output logic signed [31:0]               pulse_height,
    output logic                             trigger_lost
);

    localparam int DAW = $clog2(MAX_DIFF_LENGTH);
    localparam int AAW = $clog2(MAX_AVG_LENGTH);
    localparam int DCW = $clog2(MAX_DIFF_LENGTH + 1);
    localparam int ACW = $clog2(MAX_AVG_LENGTH + 1);

    // configuration
    logic [31:0] decay_reg;
    logic [10:0] diff_len_reg;
    logic [8:0]  avg_len_reg;
    logic [16:0] avg_recip_reg;
    logic [15:0] thr_reg;
    logic [11:0] skip_reg;
    logic [10:0] cnt_reg;
    logic [16:0] basis_recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg       <= 32'd4294698902;
            diff_len_reg    <= 11'd256;
            avg_len_reg     <= 9'd64;
            avg_recip_reg   <= 17'd1024;
            thr_reg         <= 16'd512;
            skip_reg        <= 12'd96;
            cnt_reg         <= 11'd128;
            basis_recip_reg <= 17'd512;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mwd_pkg::REG_DECAY_COEFF:    decay_reg       <= cfg_data;
                mwd_pkg::REG_DIFF_LENGTH:    diff_len_reg    <= cfg_data[10:0];
                mwd_pkg::REG_AVG_LENGTH:     avg_len_reg     <= cfg_data[8:0];
                mwd_pkg::REG_AVG_RECIP:      avg_recip_reg   <= cfg_data[16:0];
                mwd_pkg::REG_GRAD_THRESHOLD: thr_reg         <= cfg_data[15:0];
                mwd_pkg::REG_BASIS_SKIP:     skip_reg        <= cfg_data[11:0];
                mwd_pkg::REG_BASIS_COUNT:    cnt_reg         <= cfg_data[10:0];
                mwd_pkg::REG_BASIS_RECIP:    basis_recip_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clamped lengths
    logic [DCW-1:0] m_len;
    logic [ACW-1:0] l_len;
    always_comb
    begin
        if (diff_len_reg == 11'd0) m_len = DCW'(1);
        else if (32'(diff_len_reg) > MAX_DIFF_LENGTH) m_len = DCW'(MAX_DIFF_LENGTH);
        else m_len = DCW'(diff_len_reg);
        if (avg_len_reg == 9'd0) l_len = ACW'(1);
        else if (32'(avg_len_reg) > MAX_AVG_LENGTH) l_len = ACW'(MAX_AVG_LENGTH);
        else l_len = ACW'(avg_len_reg);
    end

    // state
    logic signed [SAMPLE_WIDTH-1:0] prev_x_reg, x_reg;
    logic signed [64:0] prod_reg;
    logic [47:0] acc_reg;
    logic [DAW-1:0] dptr_reg;
    logic [AAW-1:0] aptr_reg;
    logic        dfull_reg, afull_reg;
    logic [47:0] dmem [MAX_DIFF_LENGTH];
    logic [47:0] amem [MAX_AVG_LENGTH];
    logic [47:0] dold_raw_reg, aold_raw_reg;
    logic        dold_ok_reg, aold_ok_reg;
    logic [DAW-1:0] dri_reg;
    logic [AAW-1:0] ari_reg;
    logic [55:0] sum_reg;
    logic signed [48:0] scale_a_reg;
    logic [40:0] scale_b_reg;
    logic signed [31:0] prev_mwd_reg;
    logic armed_reg, settled_reg;
    logic [31:0] cnt32_reg, ltt_reg;
    logic [1:0] phase_reg;
    logic [11:0] cd_reg;
    logic [47:0] bsum_reg;
    logic res_trig_reg, res_lost_reg, res_valid_reg;

    // read indexes with wrap
    logic [DAW:0] dri_full;
    logic [AAW:0] ari_full;
    assign dri_full = {1'b0, dptr_reg} + (DAW+1)'(MAX_DIFF_LENGTH) - (DAW+1)'(m_len);
    assign ari_full = {1'b0, aptr_reg} + (AAW+1)'(MAX_AVG_LENGTH) - (AAW+1)'(l_len);

    // decay times previous sample
    logic signed [SAMPLE_WIDTH+32:0] prod_c;
    assign prod_c = $signed({1'b0, decay_reg}) * prev_x_reg;

    // load: product of decay and previous sample, read addresses
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            x_reg    <= sample;
            prod_reg <= 65'(prod_c) + 65'sd8388608;
            dri_reg  <= (dri_full >= (DAW+1)'(MAX_DIFF_LENGTH))
                        ? DAW'(dri_full - (DAW+1)'(MAX_DIFF_LENGTH)) : dri_full[DAW-1:0];
            ari_reg  <= (ari_full >= (AAW+1)'(MAX_AVG_LENGTH))
                        ? AAW'(ari_full - (AAW+1)'(MAX_AVG_LENGTH)) : ari_full[AAW-1:0];
        end
    end

    logic [47:0] acc_new;
    assign acc_new = acc_reg + 48'({{(48-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg} <<< 8)
                     - 48'(prod_reg >>> 24);

    logic [47:0] d_new;
    logic [47:0] a_old;
    assign d_new = acc_reg - (dold_ok_reg ? dold_raw_reg : 48'd0);
    assign a_old = aold_ok_reg ? aold_raw_reg : 48'd0;

    // memory reads registered
    always_ff @(posedge clk)
    begin
        if (cmd.step_deconv)
        begin
            dold_raw_reg <= dmem[dri_reg];
            aold_raw_reg <= amem[ari_reg];
            dmem[dptr_reg] <= acc_new;
        end
        if (cmd.step_diff)
            amem[aptr_reg] <= d_new;
    end

    logic [55:0] sum_new;
    assign sum_new = sum_reg + {{8{d_new[47]}}, d_new} - {{8{a_old[47]}}, a_old};

    // scale: split sum into high and low parts, two narrow products
    logic signed [31:0] s_hi;
    logic [23:0] s_lo;
    assign s_hi = $signed(sum_reg[55:24]);
    assign s_lo = sum_reg[23:0];

    logic signed [63:0] mwd_full;
    logic signed [31:0] mwd_val;
    assign mwd_full = (64'(scale_a_reg) <<< 8) + 64'($signed({1'b0, scale_b_reg[40:16]}));
    assign mwd_val  = mwd_pkg::sat32(mwd_full);

    // trigger
    logic signed [32:0] grad;
    logic signed [32:0] thr;
    assign grad = 33'(mwd_val) - 33'(prev_mwd_reg);
    assign thr  = $signed({17'd0, thr_reg});
    logic settled_now;
    assign settled_now = settled_reg ||
        ({1'b0, cnt32_reg} >= 33'(m_len) + 33'(l_len) + 33'd1);

    logic [11:0] skip_eff;
    logic [10:0] cnt_eff;
    assign skip_eff = (skip_reg == 12'd0) ? 12'd1 : skip_reg;
    assign cnt_eff  = (cnt_reg  == 11'd0) ? 11'd1 : cnt_reg;

    logic trig_c, lost_c, valid_c, armed_c;
    logic [1:0] ph_c;
    logic [11:0] cd_c;
    logic [47:0] bs_c;
    logic [31:0] ltt_c;
    always_comb
    begin
        trig_c = 1'b0; lost_c = 1'b0; valid_c = 1'b0;
        armed_c = armed_reg; ph_c = phase_reg; cd_c = cd_reg;
        bs_c = bsum_reg; ltt_c = ltt_reg;
        if (settled_now)
        begin
            if (grad < -thr && armed_reg)
            begin
                trig_c = 1'b1; armed_c = 1'b0;
                if (phase_reg == mwd_pkg::PH_WAIT || phase_reg == mwd_pkg::PH_ACCUM)
                    lost_c = 1'b1;
                else
                begin
                    ltt_c = cnt32_reg - 32'd1;
                    ph_c  = mwd_pkg::PH_WAIT;
                    cd_c  = skip_eff;
                end
            end
            if (grad > thr) armed_c = 1'b1;
        end
        if (ph_c == mwd_pkg::PH_WAIT)
        begin
            cd_c = cd_c - 12'd1;
            if (cd_c == 12'd0)
            begin
                ph_c = mwd_pkg::PH_ACCUM; cd_c = 12'(cnt_eff); bs_c = '0;
            end
        end
        if (ph_c == mwd_pkg::PH_ACCUM)
        begin
            bs_c = bs_c + 48'(mwd_val);
            cd_c = cd_c - 12'd1;
            if (cd_c == 12'd0)
            begin
                valid_c = 1'b1; ph_c = mwd_pkg::PH_IDLE;
            end
        end
        else if (ph_c != mwd_pkg::PH_WAIT)
            ph_c = mwd_pkg::PH_IDLE;
    end

    // pulse height: 48 x 17 split into two products, one stage before finish
    logic signed [47:0] ph_sum_reg;
    logic signed [40:0] ph_hi_reg;
    logic [40:0]        ph_lo_reg;
    logic signed [63:0] ph_full;
    assign ph_full = (64'(ph_hi_reg) <<< 8) + 64'($signed({1'b0, ph_lo_reg[40:16]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0; acc_reg <= '0; dptr_reg <= '0; aptr_reg <= '0;
            dfull_reg <= 1'b0; afull_reg <= 1'b0; sum_reg <= '0;
            prev_mwd_reg <= '0; armed_reg <= 1'b1; settled_reg <= 1'b0;
            cnt32_reg <= '0; ltt_reg <= '0; phase_reg <= mwd_pkg::PH_IDLE;
            cd_reg <= '0; bsum_reg <= '0;
            res_trig_reg <= 1'b0; res_lost_reg <= 1'b0; res_valid_reg <= 1'b0;
            dold_ok_reg <= 1'b0; aold_ok_reg <= 1'b0;
            mwd_out <= '0; trigger <= 1'b0; trigger_time <= '0;
            pulse_valid <= 1'b0; pulse_height <= '0; trigger_lost <= 1'b0;
        end
        else
        begin
            if (cmd.load_sample) prev_x_reg <= sample;
            if (cmd.step_deconv)
            begin
                acc_reg <= acc_new;
                // entries behind the write pointer are filled until the first wrap
                dold_ok_reg <= dfull_reg || (dri_reg < dptr_reg);
                aold_ok_reg <= afull_reg || (ari_reg < aptr_reg);
                if (32'(dptr_reg) + 1 >= MAX_DIFF_LENGTH)
                begin
                    dptr_reg  <= '0;
                    dfull_reg <= 1'b1;
                end
                else
                    dptr_reg <= dptr_reg + 1'b1;
            end
            if (cmd.step_diff)
            begin
                sum_reg <= sum_new;
                if (32'(aptr_reg) + 1 >= MAX_AVG_LENGTH)
                begin
                    aptr_reg  <= '0;
                    afull_reg <= 1'b1;
                end
                else
                    aptr_reg <= aptr_reg + 1'b1;
            end
            if (cmd.step_trig)
            begin
                settled_reg <= settled_now;
                armed_reg <= armed_c; phase_reg <= ph_c; cd_reg <= cd_c;
                bsum_reg <= bs_c; ltt_reg <= ltt_c;
                prev_mwd_reg <= mwd_val;
                cnt32_reg <= cnt32_reg + 32'd1;
                res_trig_reg <= trig_c; res_lost_reg <= lost_c;
                res_valid_reg <= valid_c;
            end
            if (cmd.step_finish)
            begin
                mwd_out <= prev_mwd_reg; trigger <= res_trig_reg;
                trigger_time <= ltt_reg; trigger_lost <= res_lost_reg;
                pulse_valid <= res_valid_reg;
                pulse_height <= res_valid_reg ? mwd_pkg::sat32(ph_full) : 32'sd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_scale)
        begin
            scale_a_reg <= 49'(s_hi * $signed({1'b0, avg_recip_reg}));
            scale_b_reg <= 41'({17'd0, s_lo} * {24'd0, avg_recip_reg}) + 41'd32768;
        end
        if (cmd.step_trig) ph_sum_reg <= $signed(bs_c);
        if (cmd.step_height)
        begin
            ph_hi_reg <= 41'($signed(ph_sum_reg[47:24]) * $signed({1'b0, basis_recip_reg}));
            ph_lo_reg <= 41'({17'd0, ph_sum_reg[23:0]} * {24'd0, basis_recip_reg})
                         + 41'd32768;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mwd_pulse_filter_trigger.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mwd_pulse_filter_trigger
// moving window deconvolution filter with gradient trigger and pulse height
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     sample
// output    out        out_valid / out_ready   mwd_out, trigger, trigger_time,
//                                              pulse_valid, pulse_height, trigger_lost
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one transaction in, one transaction out; the sequencer steps each sample
// through accept, deconvolution, delay lines, scaling, trigger, pulse-height
// product and finish, with one read and one write per delay-line memory and
// the multipliers split into narrow products
// delay lines read as zero until filled, tracked by write pointer and a wrap flag
// a finished result waits in the output register while the next sample is
// taken; finish stalls only if the previous result is still not taken
// ---------------------------------------------------------------------------
module mwd_pulse_filter_trigger #(
    parameter int MAX_DIFF_LENGTH = mwd_pkg::MAX_DIFF_LENGTH,
    parameter int MAX_AVG_LENGTH  = mwd_pkg::MAX_AVG_LENGTH,
    parameter int SAMPLE_WIDTH    = mwd_pkg::SAMPLE_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [31:0]                  mwd_out,
    output logic                                trigger,
    output logic [31:0]                         trigger_time,
    output logic                                pulse_valid,
    output logic signed [31:0]                  pulse_height,
    output logic                                trigger_lost,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    mwd_pkg::mwd_cmd_t cmd;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    mwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mwd_dp #(
        .MAX_DIFF_LENGTH (MAX_DIFF_LENGTH),
        .MAX_AVG_LENGTH  (MAX_AVG_LENGTH),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mwd_out      (mwd_out),
        .trigger      (trigger),
        .trigger_time (trigger_time),
        .pulse_valid  (pulse_valid),
        .pulse_height (pulse_height),
        .trigger_lost (trigger_lost)
    );

    a_lost_has_trig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_lost |-> trigger) else $error("lost without trigger");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mwd_out)) else $error("result changed");
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accept during work");

endmodule
`default_nettype wire

// ===== tb/sv/tb_mwd_pulse_filter_trigger.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mwd_pulse_filter_trigger
// drives samples through the mwd filter and checks every result transaction
// against a cycle-free model of the deconvolution, trapezoid, gradient
// trigger and pulse-height window, across several register settings
// ---------------------------------------------------------------------------
module tb_mwd_pulse_filter_trigger;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  SETTLE_WAIT  = 20;   // lets the sequencer run out after the last sample, leave margin
    localparam int  HOLD_LEN     = 300;  // long sink hold-off
    localparam int  HOLD_AT      = 100;  // results taken before the hold-off starts

    // expected content of one result transaction
    typedef struct {
        logic signed [31:0] mwd;
        logic               trig;
        logic [31:0]        ttime;
        logic               pvalid;
        logic signed [31:0] pheight;
        logic               lost;
    } mwd_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [15:0]       sample = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [31:0]       mwd_out;
    logic                     trigger;
    logic [31:0]              trigger_time;
    logic                     pulse_valid;
    logic signed [31:0]       pulse_height;
    logic                     trigger_lost;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [2:0]               cfg_index = '0;
    logic [31:0]              cfg_data = '0;

    mwd_pulse_filter_trigger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mwd_out      (mwd_out),
        .trigger      (trigger),
        .trigger_time (trigger_time),
        .pulse_valid  (pulse_valid),
        .pulse_height (pulse_height),
        .trigger_lost (trigger_lost),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // pending samples, expected results, bookkeeping
    logic signed [15:0] pending_samples[$];
    mwd_result_t        expected_results[$];
    int                 errors = 0;
    int                 results_taken = 0;
    int                 cycles = 0;
    bit                 burst = 1'b0;     // no gaps on either side while set
    logic               in_taken = 1'b0;
    logic               cfg_taken = 1'b0;

    // ------------------------------------------------------------------
    // filter model: register copies
    // ------------------------------------------------------------------
    longint r_decay, r_diff_len, r_avg_len, r_avg_recip;
    longint r_threshold, r_skip, r_count, r_basis_recip;

    // filter model: state
    longint             f_prev_sample;
    logic [47:0]        f_accum;
    logic [47:0]        f_diff_line[mwd_pkg::MAX_DIFF_LENGTH];
    logic [47:0]        f_avg_line[mwd_pkg::MAX_AVG_LENGTH];
    logic [55:0]        f_avg_sum;
    longint             f_prev_mwd;
    bit                 f_armed;
    logic [31:0]        f_index;
    logic [1:0]         f_phase;
    logic [11:0]        f_countdown;
    logic [47:0]        f_basis_sum;
    logic [31:0]        f_last_trig;
    int                 f_diff_ptr, f_avg_ptr;
    bit                 f_settled;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void reset_filter_model();
        r_decay = 64'd4294698902; r_diff_len = 256; r_avg_len = 64;
        r_avg_recip = 1024; r_threshold = 512; r_skip = 96;
        r_count = 128; r_basis_recip = 512;
        f_prev_sample = 0; f_accum = '0; f_avg_sum = '0; f_prev_mwd = 0;
        f_armed = 1'b1; f_index = '0; f_phase = mwd_pkg::PH_IDLE; f_countdown = '0;
        f_basis_sum = '0; f_last_trig = '0; f_diff_ptr = 0; f_avg_ptr = 0;
        f_settled = 1'b0;
        foreach (f_diff_line[i]) f_diff_line[i] = '0;
        foreach (f_avg_line[i]) f_avg_line[i] = '0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
        unique case (idx)
            mwd_pkg::REG_DECAY_COEFF:    r_decay       = longint'(val);
            mwd_pkg::REG_DIFF_LENGTH:    r_diff_len    = longint'(val[10:0]);
            mwd_pkg::REG_AVG_LENGTH:     r_avg_len     = longint'(val[8:0]);
            mwd_pkg::REG_AVG_RECIP:      r_avg_recip   = longint'(val[16:0]);
            mwd_pkg::REG_GRAD_THRESHOLD: r_threshold   = longint'(val[15:0]);
            mwd_pkg::REG_BASIS_SKIP:     r_skip        = longint'(val[11:0]);
            mwd_pkg::REG_BASIS_COUNT:    r_count       = longint'(val[10:0]);
            mwd_pkg::REG_BASIS_RECIP:    r_basis_recip = longint'(val[16:0]);
            default: ;
        endcase
    endfunction

    // advance the model by one sample and queue the result it produces
    function automatic void filter_sample(input logic signed [15:0] smp);
        longint             m, l, skip, cnt, x, term, d, d_old, s, hi, lo, mwd, grad, bs;
        logic signed [47:0] diff48;
        logic signed [47:0] old48;
        logic signed [55:0] sum56;
        logic signed [47:0] bsum48;
        logic [47:0]        a_old;
        int                 ri;
        mwd_result_t        res;

        m = r_diff_len; l = r_avg_len;
        if (m < 1) m = 1;
        if (m > mwd_pkg::MAX_DIFF_LENGTH) m = mwd_pkg::MAX_DIFF_LENGTH;
        if (l < 1) l = 1;
        if (l > mwd_pkg::MAX_AVG_LENGTH) l = mwd_pkg::MAX_AVG_LENGTH;
        skip = (r_skip == 0) ? 1 : r_skip;
        cnt  = (r_count == 0) ? 1 : r_count;
        res.trig = 1'b0; res.lost = 1'b0; res.pvalid = 1'b0; res.pheight = '0;

        // deconvolution, rounded decay term
        x = longint'(smp);
        term = (r_decay * f_prev_sample + (64'sd1 <<< 23)) >>> 24;
        f_accum = 48'(longint'(f_accum) + x * 256 - term);
        f_prev_sample = x;

        // M-step difference
        ri = int'((f_diff_ptr + mwd_pkg::MAX_DIFF_LENGTH - m) % mwd_pkg::MAX_DIFF_LENGTH);
        a_old = f_diff_line[ri];
        f_diff_line[f_diff_ptr] = f_accum;
        f_diff_ptr = (f_diff_ptr + 1 >= mwd_pkg::MAX_DIFF_LENGTH) ? 0 : f_diff_ptr + 1;
        diff48 = f_accum - a_old;
        d = diff48;

        // running sum over L differences
        ri = int'((f_avg_ptr + mwd_pkg::MAX_AVG_LENGTH - l) % mwd_pkg::MAX_AVG_LENGTH);
        old48 = f_avg_line[ri];
        d_old = old48;
        f_avg_line[f_avg_ptr] = diff48;
        f_avg_ptr = (f_avg_ptr + 1 >= mwd_pkg::MAX_AVG_LENGTH) ? 0 : f_avg_ptr + 1;
        f_avg_sum = 56'(longint'(f_avg_sum) + d - d_old);
        sum56 = f_avg_sum;
        s = sum56;

        // scale by the reciprocal in two parts to stay inside 64 bits
        hi = s >>> 24;
        lo = s - (hi <<< 24);
        mwd = clip32(hi * r_avg_recip * 256 + ((lo * r_avg_recip + 32768) >>> 16));

        // gradient trigger, belongs to the previous sample index
        if (longint'(f_index) >= m + l + 1)
            f_settled = 1'b1;
        grad = mwd - f_prev_mwd;
        if (f_settled)
        begin
            if (grad < -r_threshold && f_armed)
            begin
                res.trig = 1'b1;
                f_armed = 1'b0;
                if (f_phase == mwd_pkg::PH_WAIT || f_phase == mwd_pkg::PH_ACCUM)
                    res.lost = 1'b1;
                else
                begin
                    f_last_trig = f_index - 1;
                    f_phase = mwd_pkg::PH_WAIT;
                    f_countdown = 12'(skip);
                end
            end
            if (grad > r_threshold)
                f_armed = 1'b1;
        end

        // pulse-height window
        if (f_phase == mwd_pkg::PH_WAIT)
        begin
            f_countdown = f_countdown - 1;
            if (f_countdown == 0)
            begin
                f_phase = mwd_pkg::PH_ACCUM;
                f_countdown = 12'(cnt);
                f_basis_sum = '0;
            end
        end
        if (f_phase == mwd_pkg::PH_ACCUM)
        begin
            f_basis_sum = 48'(longint'(f_basis_sum) + mwd);
            f_countdown = f_countdown - 1;
            if (f_countdown == 0)
            begin
                bsum48 = f_basis_sum;
                bs = bsum48;
                res.pheight = 32'(clip32((bs * r_basis_recip + 32768) >>> 16));
                res.pvalid = 1'b1;
                f_phase = mwd_pkg::PH_IDLE;
            end
        end
        else if (f_phase != mwd_pkg::PH_WAIT)
            f_phase = mwd_pkg::PH_IDLE;

        f_prev_mwd = mwd;
        f_index = f_index + 1;
        res.mwd = 32'(mwd);
        res.ttime = f_last_trig;
        expected_results.push_back(res);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // sample driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge clk)
    begin
        if (in_valid && !in_taken)
            ;   // keep offering the same transaction
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (rst_n && pending_samples.size() > 0)
        begin
            sample   <= pending_samples.pop_front();
            in_valid <= 1'b1;
            send_gap <= pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // result sink: random stalls plus one long hold-off so the block backs up
    // ------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        int gap;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_taken >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            gap = pick_gap();
            stall_left <= gap;
            out_ready  <= (gap == 0);
        end
    end

    // ------------------------------------------------------------------
    // rising edge: handshakes, model update and result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mwd_result_t exp_res;
        in_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
        if (in_valid && in_ready)
            filter_sample(sample);
        if (out_valid && out_ready)
        begin
            results_taken <= results_taken + 1;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (mwd_out !== exp_res.mwd)
                begin
                    $error("mwd_out expected %0d got %0d", exp_res.mwd, mwd_out);
                    errors++;
                end
                if (trigger !== exp_res.trig)
                begin
                    $error("trigger expected %0d got %0d", exp_res.trig, trigger);
                    errors++;
                end
                if (trigger_time !== exp_res.ttime)
                begin
                    $error("trigger_time expected %0d got %0d", exp_res.ttime, trigger_time);
                    errors++;
                end
                if (pulse_valid !== exp_res.pvalid)
                begin
                    $error("pulse_valid expected %0d got %0d", exp_res.pvalid, pulse_valid);
                    errors++;
                end
                if (pulse_height !== exp_res.pheight)
                begin
                    $error("pulse_height expected %0d got %0d",
                           exp_res.pheight, pulse_height);
                    errors++;
                end
                if (trigger_lost !== exp_res.lost)
                begin
                    $error("trigger_lost expected %0d got %0d", exp_res.lost, trigger_lost);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one register write transaction, only while the filter is idle
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] decay, input logic [31:0] m,
                             input logic [31:0] l, input logic [31:0] arecip,
                             input logic [31:0] thr, input logic [31:0] skip,
                             input logic [31:0] cnt, input logic [31:0] brecip);
        write_register(mwd_pkg::REG_DECAY_COEFF, decay);
        write_register(mwd_pkg::REG_DIFF_LENGTH, m);
        write_register(mwd_pkg::REG_AVG_LENGTH, l);
        write_register(mwd_pkg::REG_AVG_RECIP, arecip);
        write_register(mwd_pkg::REG_GRAD_THRESHOLD, thr);
        write_register(mwd_pkg::REG_BASIS_SKIP, skip);
        write_register(mwd_pkg::REG_BASIS_COUNT, cnt);
        write_register(mwd_pkg::REG_BASIS_RECIP, brecip);
    endtask

    // wait until every queued sample has produced its result, then let the
    // sequencer run out before anything else changes
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || expected_results.size() != 0 || in_valid);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // step-like pulses on a noisy baseline, with some full-range junk mixed in
    task automatic queue_pulse_train(input int n);
        int level;
        level = 0;
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_samples.push_back(16'($urandom));
            else
            begin
                if ($urandom_range(0, 11) == 0)
                    level = $urandom_range(0, 40000) - 20000;
                pending_samples.push_back(16'(level + $urandom_range(0, 6) - 3));
            end
        end
    endtask

    initial
    begin
        reset_filter_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: field extremes and steps under reset settings
        pending_samples = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001,
                            16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
                            16'sh0000, 16'sh0000, 16'sh1234, -16'sh1234, 16'sh5555,
                            -16'sh5556, 16'sh4000, 16'sh4000, 16'sh0000, 16'sh7fff};
        drain();

        // short filter, pulses trigger and fill windows; the long hold-off hits here
        write_all(32'hfffbe796, 11, 4, 16384, 100, 6, 8, 8192);
        queue_pulse_train(150);
        drain();

        // extremes: lengths saturated high and low, zero skip and count, zero threshold
        burst = 1'b1;
        write_all(32'hffffffff, 32'hffffffff, 0, 65536, 0, 0, 0, 65536);
        queue_pulse_train(60);
        drain();

        // opposite extremes: M of one, L clipped, zero gains, huge threshold and skip
        burst = 1'b0;
        write_all(0, 1, 32'h0000ffff, 0, 65535, 4095, 1024, 0);
        queue_pulse_train(40);
        drain();

        // short window, frequent triggers so some land in a busy window
        write_all($urandom, 8, 8, 8192, 50, 3, 4, 16384);
        queue_pulse_train(80);
        drain();
        burst = 1'b1;
        queue_pulse_train(70);
        drain();

        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
